### hw/rtl/aaf_pkg.sv
// aaf_pkg: shared constants, operation codes, unit classes and control structs
// for the accumulator alu with flags; no dependencies
`default_nettype none

package aaf_pkg;

    localparam int WORD_BITS_DEF = 16;
    localparam int FIELD_BITS    = 16;
    localparam int OP_BITS       = 5;
    localparam int S_TDATA_BITS  = 40;
    localparam int M_TDATA_BITS  = 24;

    localparam logic [OP_BITS-1:0] OP_ADD = 5'd0;
    localparam logic [OP_BITS-1:0] OP_SUB = 5'd1;
    localparam logic [OP_BITS-1:0] OP_MUL = 5'd2;
    localparam logic [OP_BITS-1:0] OP_DIV = 5'd3;
    localparam logic [OP_BITS-1:0] OP_MOD = 5'd4;
    localparam logic [OP_BITS-1:0] OP_CMP = 5'd5;
    localparam logic [OP_BITS-1:0] OP_SHL = 5'd6;
    localparam logic [OP_BITS-1:0] OP_SHR = 5'd7;
    localparam logic [OP_BITS-1:0] OP_NEG = 5'd8;
    localparam logic [OP_BITS-1:0] OP_INC = 5'd9;
    localparam logic [OP_BITS-1:0] OP_DEC = 5'd10;
    localparam logic [OP_BITS-1:0] OP_AND = 5'd11;
    localparam logic [OP_BITS-1:0] OP_OR  = 5'd12;
    localparam logic [OP_BITS-1:0] OP_XOR = 5'd13;
    localparam logic [OP_BITS-1:0] OP_NOT = 5'd14;
    localparam logic [OP_BITS-1:0] OP_TST = 5'd15;
    localparam logic [OP_BITS-1:0] OP_EQ  = 5'd16;
    localparam logic [OP_BITS-1:0] OP_NE  = 5'd17;
    localparam logic [OP_BITS-1:0] OP_LE  = 5'd18;
    localparam logic [OP_BITS-1:0] OP_GT  = 5'd19;
    localparam logic [OP_BITS-1:0] OP_GE  = 5'd20;
    localparam logic [OP_BITS-1:0] OP_LT  = 5'd21;

    typedef enum logic [1:0] {
        CLS_SERIAL,
        CLS_ITER,
        CLS_PASS
    } aaf_cls_t;

    typedef struct packed {
        logic               start;
        logic               ack;
        logic [OP_BITS-1:0] op;
    } aaf_cmd_t;

    typedef struct packed {
        logic done;
        logic carry;
        logic ovf;
    } aaf_stat_t;

    function automatic aaf_cls_t op_class(input logic [OP_BITS-1:0] op);
        aaf_cls_t cls;
        unique case (op)
            OP_MUL, OP_DIV, OP_MOD, OP_SHL, OP_SHR: cls = CLS_ITER;
            OP_ADD, OP_SUB, OP_CMP, OP_NEG, OP_INC, OP_DEC,
            OP_AND, OP_OR, OP_XOR, OP_NOT, OP_TST: cls = CLS_SERIAL;
            default: cls = CLS_PASS;
        endcase
        return cls;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/aaf_bit_alu.sv
// aaf_bit_alu: bit-serial adder and logic unit, one bit per cycle lsb first
// depends on aaf_pkg
`default_nettype none

module aaf_bit_alu #(
    parameter int WORD_BITS = aaf_pkg::WORD_BITS_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire aaf_pkg::aaf_cmd_t     cmd,
    input  wire logic [WORD_BITS-1:0]  opa,
    input  wire logic [WORD_BITS-1:0]  opb,
    output      logic [WORD_BITS-1:0]  res,
    output      aaf_pkg::aaf_stat_t    stat
);
    import aaf_pkg::*;

    localparam int CW = $clog2(WORD_BITS);

    typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DONE} state_t;

    state_t               state_reg;
    logic [WORD_BITS-1:0] x_reg, y_reg, r_reg;
    logic                 cy_reg, nz_reg, xm_reg, ym_reg, invc_reg;
    logic [OP_BITS-1:0]   op_reg;
    logic [CW-1:0]        cnt_reg;
    logic                 sum, cout, bit_out, nz_next;

    always_comb begin
        sum     = x_reg[0] ^ y_reg[0] ^ cy_reg;
        cout    = (x_reg[0] & y_reg[0]) | (cy_reg & (x_reg[0] ^ y_reg[0]));
        nz_next = nz_reg | y_reg[0];
        unique case (op_reg)
            OP_ADD, OP_SUB, OP_CMP, OP_NEG, OP_INC, OP_DEC: bit_out = sum;
            OP_AND: bit_out = x_reg[0] & y_reg[0];
            OP_OR:  bit_out = x_reg[0] | y_reg[0];
            OP_XOR: bit_out = x_reg[0] ^ y_reg[0];
            OP_NOT: bit_out = ~y_reg[0];
            default: bit_out = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (cmd.start) begin
                        state_reg <= ST_RUN;
                        op_reg    <= cmd.op;
                        cnt_reg   <= '0;
                        nz_reg    <= 1'b0;
                        x_reg     <= opa;
                        y_reg     <= opb;
                        cy_reg    <= 1'b0;
                        invc_reg  <= 1'b0;
                        unique case (cmd.op)
                            OP_SUB, OP_CMP: begin
                                y_reg    <= ~opb;
                                cy_reg   <= 1'b1;
                                invc_reg <= 1'b1;
                            end
                            OP_INC: begin
                                x_reg  <= opb;
                                y_reg  <= '0;
                                cy_reg <= 1'b1;
                            end
                            OP_DEC: begin
                                x_reg    <= opb;
                                y_reg    <= '1;
                                invc_reg <= 1'b1;
                            end
                            OP_NEG: begin
                                x_reg  <= '0;
                                y_reg  <= ~opb;
                                cy_reg <= 1'b1;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                ST_RUN: begin
                    x_reg   <= x_reg >> 1;
                    y_reg   <= y_reg >> 1;
                    cy_reg  <= cout;
                    nz_reg  <= nz_next;
                    r_reg   <= {bit_out, r_reg[WORD_BITS-1:1]};
                    cnt_reg <= cnt_reg + CW'(1);
                    if (cnt_reg == CW'(WORD_BITS - 1)) begin
                        xm_reg    <= x_reg[0];
                        ym_reg    <= y_reg[0];
                        state_reg <= ST_DONE;
                        if (op_reg == OP_TST) begin
                            r_reg <= WORD_BITS'(nz_next);
                        end
                    end
                end
                ST_DONE: begin
                    if (cmd.ack) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign res        = r_reg;
    assign stat.done  = (state_reg == ST_DONE);
    assign stat.carry = cy_reg ^ invc_reg;
    assign stat.ovf   = (xm_reg == ym_reg) && (r_reg[WORD_BITS-1] != xm_reg);

endmodule

`default_nettype wire

### hw/rtl/aaf_iter_unit.sv
// aaf_iter_unit: radix-2 iterative unit for multiply, unsigned divide/modulo
// and one-bit-per-cycle shifts; depends on aaf_pkg
`default_nettype none

module aaf_iter_unit #(
    parameter int WORD_BITS = aaf_pkg::WORD_BITS_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire aaf_pkg::aaf_cmd_t     cmd,
    input  wire logic [WORD_BITS-1:0]  opa,
    input  wire logic [WORD_BITS-1:0]  opb,
    output      logic [WORD_BITS-1:0]  res,
    output      aaf_pkg::aaf_stat_t    stat
);
    import aaf_pkg::*;

    localparam int CW = $clog2(WORD_BITS + 1);

    typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DONE} state_t;

    state_t               state_reg;
    logic [WORD_BITS-1:0] p_reg, q_reg, d_reg;
    logic [OP_BITS-1:0]   op_reg;
    logic [CW-1:0]        cnt_reg;
    logic                 ovf_reg;
    logic [WORD_BITS:0]   trial, diff;
    logic [WORD_BITS-1:0] p_sum;
    logic                 long_shift;

    always_comb begin
        trial      = {p_reg, q_reg[WORD_BITS-1]};
        diff       = trial - {1'b0, d_reg};
        p_sum      = p_reg + d_reg;
        long_shift = ({1'b0, opb} >= (WORD_BITS + 1)'(WORD_BITS));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ovf_reg   <= 1'b0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (cmd.start) begin
                        op_reg    <= cmd.op;
                        state_reg <= ST_RUN;
                        unique case (cmd.op)
                            OP_MUL: begin
                                p_reg   <= '0;
                                q_reg   <= opb;
                                d_reg   <= opa;
                                cnt_reg <= CW'(WORD_BITS);
                            end
                            OP_DIV, OP_MOD: begin
                                p_reg   <= '0;
                                d_reg   <= opb;
                                cnt_reg <= CW'(WORD_BITS);
                                if (opb == '0) begin
                                    q_reg     <= '0;
                                    ovf_reg   <= 1'b1;
                                    state_reg <= ST_DONE;
                                end else begin
                                    q_reg   <= opa;
                                    ovf_reg <= 1'b0;
                                end
                            end
                            default: begin
                                if (long_shift) begin
                                    p_reg     <= '0;
                                    cnt_reg   <= '0;
                                    state_reg <= ST_DONE;
                                end else begin
                                    p_reg   <= opa;
                                    cnt_reg <= CW'(opb);
                                    if (opb == '0) begin
                                        state_reg <= ST_DONE;
                                    end
                                end
                            end
                        endcase
                    end
                end
                ST_RUN: begin
                    cnt_reg <= cnt_reg - CW'(1);
                    if (cnt_reg == CW'(1)) begin
                        state_reg <= ST_DONE;
                    end
                    unique case (op_reg)
                        OP_MUL: begin
                            if (q_reg[0]) begin
                                p_reg <= p_sum;
                            end
                            d_reg <= d_reg << 1;
                            q_reg <= q_reg >> 1;
                        end
                        OP_DIV, OP_MOD: begin
                            if (!diff[WORD_BITS]) begin
                                p_reg <= diff[WORD_BITS-1:0];
                                q_reg <= {q_reg[WORD_BITS-2:0], 1'b1};
                            end else begin
                                p_reg <= trial[WORD_BITS-1:0];
                                q_reg <= {q_reg[WORD_BITS-2:0], 1'b0};
                            end
                        end
                        OP_SHL: p_reg <= p_reg << 1;
                        default: p_reg <= p_reg >> 1;
                    endcase
                end
                ST_DONE: begin
                    if (cmd.ack) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign res        = (op_reg == OP_DIV) ? q_reg : p_reg;
    assign stat.done  = (state_reg == ST_DONE);
    assign stat.carry = 1'b0;
    assign stat.ovf   = ovf_reg;

endmodule

`default_nettype wire

### hw/rtl/accumulator_alu_with_flags_top.sv
// accumulator_alu_with_flags_top: arithmetic, logic, multiply, divide and modulo
// run one bit per cycle in the serial or iterative unit; a zero divisor and shifts by
// zero or at least WORD_BITS finish without iterating, other shifts run one step per
// bit of the amount; conditions and unused codes use no unit. one item in flight.
// reset (aresetn low, synchronous) clears N, Z, C, O and valids.
// depends on aaf_pkg, aaf_bit_alu and aaf_iter_unit
`default_nettype none

module accumulator_alu_with_flags_top #(
    parameter int WORD_BITS = aaf_pkg::WORD_BITS_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output      logic                              s_tready,
    // operation[4:0], operand_stack[20:5], operand_acc[36:21], zero fill
    input  wire logic [aaf_pkg::S_TDATA_BITS-1:0]  s_tdata,
    output      logic                              m_tvalid,
    input  wire logic                              m_tready,
    // result[15:0], acc_written[16], negative_flag[17], zero_flag[18],
    // carry_flag[19], overflow_flag[20], branch_taken[21], zero fill
    output      logic [aaf_pkg::M_TDATA_BITS-1:0]  m_tdata
);
    import aaf_pkg::*;

    logic [OP_BITS-1:0]    in_op;
    logic [WORD_BITS-1:0]  in_a, in_b;
    aaf_cls_t              in_cls;
    logic                  accept, finish;

    logic                  busy_reg;
    logic [OP_BITS-1:0]    op_reg;
    aaf_cls_t              cls_reg;
    logic [WORD_BITS-1:0]  b_reg;
    logic                  n_reg, z_reg, c_reg, o_reg;
    logic                  m_tvalid_reg;
    logic [M_TDATA_BITS-1:0] m_tdata_reg;

    aaf_cmd_t              ser_cmd, itr_cmd;
    aaf_stat_t             ser_stat, itr_stat;
    logic [WORD_BITS-1:0]  ser_res, itr_res;

    logic [WORD_BITS-1:0]  res_sel;
    logic                  unit_done, wr, br, nxo;
    logic                  n_next, z_next, c_next, o_next;

    assign in_op  = s_tdata[OP_BITS-1:0];
    assign in_a   = WORD_BITS'(s_tdata[OP_BITS+FIELD_BITS-1:OP_BITS]);
    assign in_b   = WORD_BITS'(s_tdata[OP_BITS+2*FIELD_BITS-1:OP_BITS+FIELD_BITS]);
    assign in_cls = op_class(in_op);

    assign s_tready = !busy_reg;
    assign accept   = s_tvalid && s_tready;

    assign ser_cmd.start = accept && (in_cls == CLS_SERIAL);
    assign ser_cmd.ack   = finish;
    assign ser_cmd.op    = in_op;
    assign itr_cmd.start = accept && (in_cls == CLS_ITER);
    assign itr_cmd.ack   = finish;
    assign itr_cmd.op    = in_op;

    aaf_bit_alu #(.WORD_BITS(WORD_BITS)) u_bit_alu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (ser_cmd),
        .opa     (in_a),
        .opb     (in_b),
        .res     (ser_res),
        .stat    (ser_stat)
    );

    aaf_iter_unit #(.WORD_BITS(WORD_BITS)) u_iter_unit (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (itr_cmd),
        .opa     (in_a),
        .opb     (in_b),
        .res     (itr_res),
        .stat    (itr_stat)
    );

    always_comb begin
        unique case (cls_reg)
            CLS_SERIAL: begin
                res_sel   = ser_res;
                unit_done = ser_stat.done;
            end
            CLS_ITER: begin
                res_sel   = itr_res;
                unit_done = itr_stat.done;
            end
            default: begin
                res_sel   = b_reg;
                unit_done = 1'b1;
            end
        endcase

        finish = busy_reg && unit_done && (!m_tvalid_reg || m_tready);

        n_next = n_reg;
        z_next = z_reg;
        c_next = c_reg;
        o_next = o_reg;
        wr     = 1'b1;
        br     = 1'b0;
        nxo    = n_reg ^ o_reg;

        unique case (op_reg)
            OP_ADD, OP_SUB, OP_CMP, OP_INC, OP_DEC: begin
                n_next = res_sel[WORD_BITS-1];
                z_next = (res_sel == '0);
                c_next = ser_stat.carry;
                o_next = ser_stat.ovf;
                wr     = (op_reg != OP_CMP);
            end
            OP_DIV, OP_MOD: begin
                n_next = res_sel[WORD_BITS-1];
                z_next = (res_sel == '0);
                o_next = itr_stat.ovf;
            end
            OP_MUL, OP_SHL, OP_SHR, OP_NEG, OP_AND, OP_OR, OP_XOR, OP_NOT, OP_TST: begin
                n_next = res_sel[WORD_BITS-1];
                z_next = (res_sel == '0);
            end
            OP_EQ: begin wr = 1'b0; br = z_reg; end
            OP_NE: begin wr = 1'b0; br = !z_reg; end
            OP_LE: begin wr = 1'b0; br = z_reg | nxo; end
            OP_GT: begin wr = 1'b0; br = !(z_reg | nxo); end
            OP_GE: begin wr = 1'b0; br = z_reg | !nxo; end
            OP_LT: begin wr = 1'b0; br = !z_reg & nxo; end
            default: wr = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
            n_reg        <= 1'b0;
            z_reg        <= 1'b0;
            c_reg        <= 1'b0;
            o_reg        <= 1'b0;
            cls_reg      <= CLS_PASS;
        end else begin
            if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (accept) begin
                busy_reg <= 1'b1;
                op_reg   <= in_op;
                cls_reg  <= in_cls;
                b_reg    <= in_b;
            end
            if (finish) begin
                busy_reg     <= 1'b0;
                m_tvalid_reg <= 1'b1;
                n_reg        <= n_next;
                z_reg        <= z_next;
                c_reg        <= c_next;
                o_reg        <= o_next;
                m_tdata_reg  <= {2'b00, br, o_next, c_next, z_next, n_next, wr,
                                 FIELD_BITS'(wr ? res_sel : b_reg)};
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire
